// ===== hw/rtl/glushkov_nfa_byte_step_core_defines.svh =====
// Assertion macros for the matcher core.
`ifndef GLUSHKOV_NFA_BYTE_STEP_CORE_DEFINES_SVH
`define GLUSHKOV_NFA_BYTE_STEP_CORE_DEFINES_SVH
// Implication checked every clock, quiet during reset.
`define GNB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication checked on the next clock.
`define GNB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hw/rtl/gnb_pkg.sv =====
// ----------------------------------------------------------------------------
// gnb_pkg
// Shared types and constants of the position-automaton byte scanner.
// ----------------------------------------------------------------------------
`default_nettype none
package gnb_pkg;
  localparam int unsigned POSITIONS = 32;
  localparam int unsigned POS_W = $clog2(POSITIONS);
  localparam int unsigned OFF_W = 32;
  localparam logic [1:0] REQ_SCAN = 2'd0;
  localparam logic [1:0] REQ_CLASS = 2'd1;
  localparam logic [1:0] REQ_FOLLOW = 2'd2;
  localparam logic [1:0] CFG_INITIAL = 2'd0;
  localparam logic [1:0] CFG_ACCEPT = 2'd1;
  localparam logic [1:0] CFG_ANCHOR_S = 2'd2;
  localparam logic [1:0] CFG_ANCHOR_E = 2'd3;
  typedef logic [POSITIONS-1:0] pos_set_t;
  typedef logic [OFF_W-1:0] off_t;
  // memory access from the sequencer
  typedef struct packed {
    logic             wr;
    logic [POS_W-1:0] addr;
    off_t             wdata;
  } som_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/gnb_ram.sv =====
// ----------------------------------------------------------------------------
// gnb_ram
// Generic single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module gnb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/glushkov_nfa_byte_step_core.sv =====
// ----------------------------------------------------------------------------
// glushkov_nfa_byte_step_core
// Position-automaton regex matcher over a byte stream, one byte per item.
// ----------------------------------------------------------------------------
// channel | signals                                   | direction
// in      | in_valid/in_ready, req_type..last_byte    | into block
// out     | out_valid/out_ready, match_*              | out of block
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | into block
//
// A scan byte takes two passes: one pass over the start-offset RAM gathers the
// minimum per new position (read one predecessor row a cycle), a second pass
// writes back and finds the match start. Class and follow tables live in RAMs.
// A table load is written when accepted and leaves the input ready.
// Reset (rst, synchronous) clears control, active set, offset and cfg registers, not the RAMs.
// A pending result holds in the output register while loads and the next scan
// proceed; a scan that hits waits in its final step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "glushkov_nfa_byte_step_core_defines.svh"
module glushkov_nfa_byte_step_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           req_type,
  input  wire logic [7:0]           byte_value,
  input  wire logic [4:0]           row_index,
  input  wire logic [31:0]          row_bits,
  input  wire logic                 first_byte,
  input  wire logic                 last_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      match_found,
  output logic [31:0]               match_start,
  output logic [31:0]               match_end,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);
  import gnb_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CLS, S_GATHER, S_WB, S_DONE} st_t;
  st_t state;

  pos_set_t initial_set, accept_set;
  logic start_lock, end_lock;
  pos_set_t active_set, fresh, reach, cur_active;
  off_t byte_offset, off;
  logic restart, last_q;
  logic [POS_W:0] k;
  off_t cand [POSITIONS];
  off_t cand_upd [POSITIONS];
  off_t som;
  pos_set_t cls_row;

  // class RAM: written on load, read for scan
  logic cls_we;
  logic [7:0] cls_addr;
  logic [31:0] cls_rd;
  gnb_ram #(.WIDTH(32), .DEPTH(256)) u_cls (
    .clk(clk), .we(cls_we), .addr(cls_addr), .wdata(row_bits), .rdata(cls_rd));

  // follow RAM
  logic fol_we;
  logic [POS_W-1:0] fol_addr;
  logic [31:0] fol_rd;
  gnb_ram #(.WIDTH(32), .DEPTH(POSITIONS)) u_fol (
    .clk(clk), .we(fol_we), .addr(fol_addr), .wdata(row_bits), .rdata(fol_rd));

  // start-offset RAM
  som_req_t som_req;
  off_t som_rd;
  gnb_ram #(.WIDTH(OFF_W), .DEPTH(POSITIONS)) u_som (
    .clk(clk), .we(som_req.wr), .addr(som_req.addr), .wdata(som_req.wdata),
    .rdata(som_rd));

  logic in_acc;
  logic hit, done_go;
  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc = in_valid && in_ready;

  // offset this scan byte runs at
  assign off = first_byte ? '0 : byte_offset;

  // report a match once the accept and end-anchor conditions hold
  assign hit = ((fresh & accept_set) != '0) && (!end_lock || last_q);
  // leave the final step unless a new report finds the output register busy
  assign done_go = (state == S_DONE) && (!hit || !out_valid || out_ready);

  logic [POS_W-1:0] kp;      // row presented last cycle
  assign kp = k[POS_W-1:0] - POS_W'(1);

  always_comb begin
    cls_we = in_acc && (req_type == REQ_CLASS);
    cls_addr = byte_value;
    fol_we = in_acc && (req_type == REQ_FOLLOW);
    fol_addr = in_acc ? row_index : k[POS_W-1:0];
    som_req.wr = (state == S_WB) && fresh[k[POS_W-1:0]];
    som_req.addr = k[POS_W-1:0];
    som_req.wdata = cand[k[POS_W-1:0]];
  end

  // Gather pass: k presents row k; data for row kp arrives this cycle.
  logic gvalid;

  // Per-position minimum: fold in the predecessor row that is visible now, and
  // on the last gather step the restart offset for initial positions.
  always_comb begin
    for (int j = 0; j < POSITIONS; j++) begin
      cand_upd[j] = cand[j];
      if (gvalid && cur_active[kp] && fol_rd[j] && cls_row[j] && som_rd < cand[j]) begin
        cand_upd[j] = som_rd;
      end
      if (k == (POS_W+1)'(POSITIONS) && restart && initial_set[j]
          && byte_offset < cand_upd[j]) begin
        cand_upd[j] = byte_offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      active_set <= '0;
      byte_offset <= '0;
      initial_set <= '0;
      accept_set <= '0;
      start_lock <= 1'b0;
      end_lock <= 1'b0;
      gvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_INITIAL: initial_set <= cfg_data[POSITIONS-1:0];
          CFG_ACCEPT: accept_set <= cfg_data[POSITIONS-1:0];
          CFG_ANCHOR_S: start_lock <= cfg_data[0];
          CFG_ANCHOR_E: end_lock <= cfg_data[0];
          default: ;
        endcase
      end
      if (done_go && hit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && req_type == REQ_SCAN) begin
            cur_active <= first_byte ? '0 : active_set;
            restart <= !(start_lock && off != '0);
            byte_offset <= off;
            last_q <= last_byte;
            reach <= '0;
            k <= '0;
            state <= S_CLS;
          end
        end
        S_CLS: begin
          // class row read is registered; capture and start the walk
          cls_row <= cls_rd[POSITIONS-1:0];
          for (int j = 0; j < POSITIONS; j++) begin
            cand[j] <= '1;
          end
          k <= '0;
          gvalid <= 1'b0;
          state <= S_GATHER;
        end
        S_GATHER: begin
          // row kp of follow and start-offset RAMs is visible now
          if (gvalid && cur_active[kp]) begin
            reach <= reach | fol_rd[POSITIONS-1:0];
          end
          for (int j = 0; j < POSITIONS; j++) begin
            cand[j] <= cand_upd[j];
          end
          if (k == (POS_W+1)'(POSITIONS)) begin
            state <= S_WB;
            k <= '0;
            gvalid <= 1'b0;
            fresh <= (reach | ((gvalid && cur_active[kp]) ?
                      fol_rd[POSITIONS-1:0] : '0) | (restart ? initial_set : '0))
                     & cls_row;
            som <= '1;
          end else begin
            k <= k + 1'b1;
            gvalid <= 1'b1;
          end
        end
        S_WB: begin
          if (fresh[k[POS_W-1:0]] && accept_set[k[POS_W-1:0]]
              && cand[k[POS_W-1:0]] < som) begin
            som <= cand[k[POS_W-1:0]];
          end
          if (k == (POS_W+1)'(POSITIONS-1)) begin
            state <= S_DONE;
          end
          k <= k + 1'b1;
        end
        S_DONE: begin
          // hold here while this scan hits and an earlier report still occupies the output
          if (done_go) begin
            active_set <= fresh;
            byte_offset <= (byte_offset == '1) ? '1 : byte_offset + 1'b1;
            if (hit) begin
              match_found <= 1'b1;
              match_start <= som;
              match_end <= (byte_offset == '1) ? '1 : byte_offset + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GNB_ASSERT_IMP(a_no_accept_busy, state != S_IDLE, !in_ready, "accepted while busy")
  `GNB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `GNB_ASSERT_NEXT(a_scan_starts, in_acc && req_type == REQ_SCAN, state == S_CLS, "scan lost")
endmodule
`default_nettype wire
